/* rtl/core/sorted_deadline_timer_queue_unit_macros.svh */
// Assertion macros for the sorted deadline timer queue.
// Depends on: a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SDTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdtq: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SDTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdtq: next-cycle check failed");

`endif

/* rtl/core/sdtq_pkg.sv */
// Shared types and codes for the sorted deadline timer queue.
// No dependencies; used by sdtq_cell, sdtq_chain and the top level.
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int ID_W    = 4;
    localparam int DELAY_W = 31;
    localparam int UTAG_W  = 16;

    // input function codes
    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SET_REPLY    = 2'd0;
    localparam logic [1:0] KIND_CANCEL_REPLY = 2'd1;
    localparam logic [1:0] KIND_EXPIRED      = 2'd2;
    localparam logic [1:0] KIND_SUMMARY      = 2'd3;

    // cell chain operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay;
        logic [UTAG_W-1:0]  user_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_W-1:0]    timer_out;
        logic [UTAG_W-1:0]  tag_out;
        logic               flag;
        logic [DELAY_W-1:0] next_delay;
        logic               none_pending;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] id;
    } cell_cmd_t;

    typedef struct packed {
        logic            head_valid;
        logic [ID_W-1:0] head_timer;
        logic            hit;
        logic            full;
    } chain_stat_t;

endpackage

/* rtl/core/sdtq_cell.sv */
// One queue slot of the timer chain: valid, timer id, deadline and tag.
// Depends on sdtq_pkg; instantiated in a row by sdtq_chain.
`timescale 1ns / 1ps

module sdtq_cell #(
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sdtq_pkg::cell_cmd_t           cmd,
    input  logic [TIME_BITS-1:0]          new_deadline,
    input  logic [TAG_BITS-1:0]           new_tag,
    input  logic                          left_valid,
    input  logic [sdtq_pkg::ID_W-1:0]     left_timer,
    input  logic [TIME_BITS-1:0]          left_deadline,
    input  logic [TAG_BITS-1:0]           left_tag,
    input  logic                          right_valid,
    input  logic [sdtq_pkg::ID_W-1:0]     right_timer,
    input  logic [TIME_BITS-1:0]          right_deadline,
    input  logic [TAG_BITS-1:0]           right_tag,
    input  logic                          carry_in,
    output logic                          carry_out,
    output logic                          valid,
    output logic [sdtq_pkg::ID_W-1:0]     timer,
    output logic [TIME_BITS-1:0]          deadline,
    output logic [TAG_BITS-1:0]           tag
);

    logic                      valid_reg, valid_next;
    logic [sdtq_pkg::ID_W-1:0] timer_reg, timer_next;
    logic [TIME_BITS-1:0]      deadline_reg, deadline_next;
    logic [TAG_BITS-1:0]       tag_reg, tag_next;
    logic [TIME_BITS-1:0]      dl_diff;
    logic                      match;
    logic                      later;
    logic                      place;

    // local compares: id match for removal, wrap-safe "later" for insertion
    assign match   = valid_reg && (timer_reg == cmd.id);
    assign dl_diff = deadline_reg - new_deadline;
    assign later   = valid_reg && (dl_diff != '0) && !dl_diff[TIME_BITS-1];
    assign place   = later || !valid_reg;

    // ripple the position flag to the right neighbor
    always_comb begin
        case (cmd.op)
            sdtq_pkg::OP_REMOVE: carry_out = carry_in || match;
            sdtq_pkg::OP_INSERT: carry_out = carry_in || place;
            default:             carry_out = carry_in;
        endcase
    end

    // pick hold, take right neighbor, take left neighbor or take new entry
    always_comb begin
        valid_next    = valid_reg;
        timer_next    = timer_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        case (cmd.op)
            sdtq_pkg::OP_REMOVE: begin
                if (carry_in || match) begin
                    valid_next    = right_valid;
                    timer_next    = right_timer;
                    deadline_next = right_deadline;
                    tag_next      = right_tag;
                end
            end
            sdtq_pkg::OP_INSERT: begin
                if (carry_in) begin
                    valid_next    = left_valid;
                    timer_next    = left_timer;
                    deadline_next = left_deadline;
                    tag_next      = left_tag;
                end else if (place) begin
                    valid_next    = 1'b1;
                    timer_next    = cmd.id;
                    deadline_next = new_deadline;
                    tag_next      = new_tag;
                end
            end
            sdtq_pkg::OP_POP: begin
                valid_next    = right_valid;
                timer_next    = right_timer;
                deadline_next = right_deadline;
                tag_next      = right_tag;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        timer_reg    <= timer_next;
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
    end

    assign valid    = valid_reg;
    assign timer    = timer_reg;
    assign deadline = deadline_reg;
    assign tag      = tag_reg;

endmodule

/* rtl/core/sdtq_chain.sv */
// Row of sdtq_cell slots forming the deadline-sorted queue, head at slot 0.
// Depends on sdtq_pkg and sdtq_cell.
`timescale 1ns / 1ps

module sdtq_chain #(
    parameter int TIMER_COUNT = 16,
    parameter int TIME_BITS   = 32,
    parameter int TAG_BITS    = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sdtq_pkg::cell_cmd_t       cmd,
    input  logic [TIME_BITS-1:0]      new_deadline,
    input  logic [TAG_BITS-1:0]       new_tag,
    output sdtq_pkg::chain_stat_t     stat,
    output logic [TIME_BITS-1:0]      head_deadline,
    output logic [TAG_BITS-1:0]       head_tag
);

    // slot outputs padded with an empty entry at each end
    logic                      ext_valid    [TIMER_COUNT+2];
    logic [sdtq_pkg::ID_W-1:0] ext_timer    [TIMER_COUNT+2];
    logic [TIME_BITS-1:0]      ext_deadline [TIMER_COUNT+2];
    logic [TAG_BITS-1:0]       ext_tag      [TIMER_COUNT+2];
    logic                      carry        [TIMER_COUNT+1];

    assign ext_valid[0]                = 1'b0;
    assign ext_timer[0]                = '0;
    assign ext_deadline[0]             = '0;
    assign ext_tag[0]                  = '0;
    assign ext_valid[TIMER_COUNT+1]    = 1'b0;
    assign ext_timer[TIMER_COUNT+1]    = '0;
    assign ext_deadline[TIMER_COUNT+1] = '0;
    assign ext_tag[TIMER_COUNT+1]      = '0;
    assign carry[0]                    = 1'b0;

    for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_slot
        sdtq_cell #(
            .TIME_BITS (TIME_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .cmd            (cmd),
            .new_deadline   (new_deadline),
            .new_tag        (new_tag),
            .left_valid     (ext_valid[i]),
            .left_timer     (ext_timer[i]),
            .left_deadline  (ext_deadline[i]),
            .left_tag       (ext_tag[i]),
            .right_valid    (ext_valid[i+2]),
            .right_timer    (ext_timer[i+2]),
            .right_deadline (ext_deadline[i+2]),
            .right_tag      (ext_tag[i+2]),
            .carry_in       (carry[i]),
            .carry_out      (carry[i+1]),
            .valid          (ext_valid[i+1]),
            .timer          (ext_timer[i+1]),
            .deadline       (ext_deadline[i+1]),
            .tag            (ext_tag[i+1])
        );
    end

    // head slot and chain-end status
    assign stat.head_valid = ext_valid[1];
    assign stat.head_timer = ext_timer[1];
    assign stat.hit        = carry[TIMER_COUNT];
    assign stat.full       = ext_valid[TIMER_COUNT];
    assign head_deadline   = ext_deadline[1];
    assign head_tag        = ext_tag[1];

endmodule

/* rtl/core/sorted_deadline_timer_queue_unit.sv */
// Sorted deadline timer queue: up to TIMER_COUNT one-shot timers held in a row of
// cells ordered by wrap-safe deadline, plus a TIME_BITS time counter that each tick
// advances. A set runs a removal pass along the cell row, then an insertion pass,
// and a cancel runs a removal pass, then the reply. A tick advances time, pops the
// head cell once per expired timer, then gives the summary. The cycle time is
// set by the position flag that ripples across the cell row. Results wait in an
// output register, so a new item can be taken while the last result is pending.
// No clearing pass after reset is needed; the queue is empty as soon as reset ends.
// Depends on sdtq_pkg, sdtq_chain, sdtq_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_deadline_timer_queue_unit_macros.svh"

module sorted_deadline_timer_queue_unit #(
    parameter int TIMER_COUNT = 16,
    parameter int TIME_BITS   = 32,
    parameter int TAG_BITS    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdtq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sdtq_pkg::out_item_t m_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_REPLY  = 2'd2;
    localparam logic [1:0] ST_TICK   = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [TIME_BITS-1:0]      now_reg, now_next;
    logic [sdtq_pkg::ID_W-1:0] req_id_reg, req_id_next;
    logic [TIME_BITS-1:0]      req_dl_reg, req_dl_next;
    logic [TAG_BITS-1:0]       req_tag_reg, req_tag_next;
    logic                      was_reg, was_next;
    logic                      out_valid_reg, out_valid_next;
    sdtq_pkg::out_item_t       out_data_reg, out_data_next;

    sdtq_pkg::cell_cmd_t       cmd;
    sdtq_pkg::chain_stat_t     stat;
    logic [TIME_BITS-1:0]      head_deadline;
    logic [TAG_BITS-1:0]       head_tag;
    logic [TIME_BITS-1:0]      head_diff;
    logic                      head_expired;
    logic                      delay_sat;
    logic [sdtq_pkg::DELAY_W-1:0] head_delay;
    logic                      in_xfer;
    logic                      out_free;
    logic                      out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    sdtq_chain #(
        .TIMER_COUNT (TIMER_COUNT),
        .TIME_BITS   (TIME_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_chain (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .new_deadline  (req_dl_reg),
        .new_tag       (req_tag_reg),
        .stat          (stat),
        .head_deadline (head_deadline),
        .head_tag      (head_tag)
    );

    // head expiry and saturated delay to the head deadline
    assign head_diff    = head_deadline - now_reg;
    assign head_expired = stat.head_valid &&
                          ((head_diff == '0) || head_diff[TIME_BITS-1]);
    assign delay_sat    = (head_diff >> sdtq_pkg::DELAY_W) != '0;
    assign head_delay   = delay_sat ? '1 : sdtq_pkg::DELAY_W'(head_diff);

    // sequence each item and build its results
    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        req_id_next   = req_id_reg;
        req_dl_next   = req_dl_reg;
        req_tag_next  = req_tag_reg;
        was_next      = was_reg;
        cmd.op        = sdtq_pkg::OP_HOLD;
        cmd.id        = req_id_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (s_data.func)
                        sdtq_pkg::FUNC_SET: begin
                            cmd.op       = sdtq_pkg::OP_REMOVE;
                            cmd.id       = s_data.timer_id;
                            was_next     = stat.hit;
                            req_id_next  = s_data.timer_id;
                            req_dl_next  = now_reg + TIME_BITS'(s_data.delay);
                            req_tag_next = TAG_BITS'(s_data.user_tag);
                            state_next   = ST_INSERT;
                        end
                        sdtq_pkg::FUNC_CANCEL: begin
                            cmd.op      = sdtq_pkg::OP_REMOVE;
                            cmd.id      = s_data.timer_id;
                            was_next    = stat.hit;
                            req_id_next = s_data.timer_id;
                            state_next  = ST_REPLY;
                        end
                        sdtq_pkg::FUNC_TICK: begin
                            now_next   = now_reg + TIME_BITS'(1);
                            state_next = ST_TICK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    if (!stat.full) begin
                        cmd.op = sdtq_pkg::OP_INSERT;
                    end
                    out_load      = 1'b1;
                    out_data_next = '0;
                    out_data_next.kind      = sdtq_pkg::KIND_SET_REPLY;
                    out_data_next.timer_out = req_id_reg;
                    out_data_next.flag      = !stat.full && !was_reg;
                    out_data_next.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data_next = '0;
                    out_data_next.kind      = sdtq_pkg::KIND_CANCEL_REPLY;
                    out_data_next.timer_out = req_id_reg;
                    out_data_next.flag      = was_reg;
                    out_data_next.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data_next = '0;
                    if (head_expired) begin
                        cmd.op = sdtq_pkg::OP_POP;
                        out_data_next.kind      = sdtq_pkg::KIND_EXPIRED;
                        out_data_next.timer_out = stat.head_timer;
                        out_data_next.tag_out   = sdtq_pkg::UTAG_W'(head_tag);
                    end else begin
                        out_data_next.kind         = sdtq_pkg::KIND_SUMMARY;
                        out_data_next.next_delay   = stat.head_valid ? head_delay : '0;
                        out_data_next.none_pending = !stat.head_valid;
                        out_data_next.last         = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold the result until the downstream transfer
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_id_reg   <= req_id_next;
        req_dl_reg   <= req_dl_next;
        req_tag_reg  <= req_tag_next;
        was_reg      <= was_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `SDTQ_ASSERT_NEXT(a_tick_advances, in_xfer && (s_data.func == sdtq_pkg::FUNC_TICK), now_reg == TIME_BITS'($past(now_reg) + TIME_BITS'(1)))
    `SDTQ_ASSERT_NOW(a_expired_not_last, m_valid && (m_data.kind == sdtq_pkg::KIND_EXPIRED), !m_data.last)
    `SDTQ_ASSERT_NEXT(a_full_set_flag, (state_reg == ST_INSERT) && out_free && stat.full, m_valid && !m_data.flag)

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the sorted deadline timer queue unit.
// Depends on sdtq_pkg and sorted_deadline_timer_queue_unit; reads no files.
`timescale 1ns / 1ps

module testbench;

    localparam int              TIMER_SLOTS = 16;
    localparam logic [1:0]      FUNC_UNUSED = 2'd3;
    localparam logic [30:0]     DELAY_LIMIT = 31'h7FFF_FFFF;
    localparam int              RANDOM_PER_PHASE = 72;

    // how the expectation of one directed transfer is formed
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_ONE_TYPED,
        CHECK_NO_RESULT
    } check_mode_t;

    typedef struct {
        sdtq_pkg::in_item_t  cmd;
        check_mode_t         mode;
        sdtq_pkg::out_item_t typed;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sdtq_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sdtq_pkg::out_item_t m_data;

    // expectation attached to the command on the input channel
    check_mode_t         cmd_check = CHECK_MODEL;
    sdtq_pkg::out_item_t cmd_typed = '0;

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;

    // predicted timer queue state
    logic [31:0] now_ticks;
    int          armed_count;
    logic [3:0]  armed_id[TIMER_SLOTS];
    logic [31:0] armed_deadline[TIMER_SLOTS];
    logic [15:0] armed_tag[TIMER_SLOTS];

    sdtq_pkg::out_item_t pending_results[$];
    stim_row_t           directed_rows[$];

    sorted_deadline_timer_queue_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Wrap-safe compare: a is later than b when a - b is nonzero and below half range
    function automatic bit deadline_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return (diff != 32'd0) && !diff[31];
    endfunction

    // Close the gap left by slot pos
    task automatic drop_slot(int pos);
        int i;
        for (i = pos; i + 1 < armed_count; i++) begin
            armed_id[i]       = armed_id[i + 1];
            armed_deadline[i] = armed_deadline[i + 1];
            armed_tag[i]      = armed_tag[i + 1];
        end
        armed_count--;
    endtask

    task automatic unlink_timer(logic [3:0] id, output bit found);
        int pos;
        pos = 0;
        found = 1'b0;
        while (pos < armed_count && armed_id[pos] != id) pos++;
        if (pos < armed_count) begin
            drop_slot(pos);
            found = 1'b1;
        end
    endtask

    // Apply one command to the predicted queue; queue its results when publish is set
    task automatic step_timer_model(sdtq_pkg::in_item_t cmd, bit publish);
        sdtq_pkg::out_item_t r;
        bit          was_armed;
        bit          queued;
        logic [31:0] due;
        logic [31:0] gap;
        int          pos;
        int          i;
        r = '0;
        case (cmd.func)
            sdtq_pkg::FUNC_SET: begin
                unlink_timer(cmd.timer_id, was_armed);
                queued = 1'b0;
                if (armed_count < TIMER_SLOTS) begin
                    due = now_ticks + {1'b0, cmd.delay};
                    // equal deadlines keep arrival order
                    pos = 0;
                    while (pos < armed_count && !deadline_after(armed_deadline[pos], due))
                        pos++;
                    for (i = armed_count; i > pos; i--) begin
                        armed_id[i]       = armed_id[i - 1];
                        armed_deadline[i] = armed_deadline[i - 1];
                        armed_tag[i]      = armed_tag[i - 1];
                    end
                    armed_id[pos]       = cmd.timer_id;
                    armed_deadline[pos] = due;
                    armed_tag[pos]      = cmd.user_tag;
                    armed_count++;
                    queued = 1'b1;
                end
                r.kind      = sdtq_pkg::KIND_SET_REPLY;
                r.timer_out = cmd.timer_id;
                r.flag      = queued && !was_armed;
                r.last      = 1'b1;
                if (publish) pending_results.push_back(r);
            end
            sdtq_pkg::FUNC_CANCEL: begin
                unlink_timer(cmd.timer_id, was_armed);
                r.kind      = sdtq_pkg::KIND_CANCEL_REPLY;
                r.timer_out = cmd.timer_id;
                r.flag      = was_armed;
                r.last      = 1'b1;
                if (publish) pending_results.push_back(r);
            end
            sdtq_pkg::FUNC_TICK: begin
                now_ticks = now_ticks + 32'd1;
                // pop every due timer from the head
                while (armed_count > 0 && !deadline_after(armed_deadline[0], now_ticks)) begin
                    r           = '0;
                    r.kind      = sdtq_pkg::KIND_EXPIRED;
                    r.timer_out = armed_id[0];
                    r.tag_out   = armed_tag[0];
                    if (publish) pending_results.push_back(r);
                    drop_slot(0);
                end
                r      = '0;
                r.kind = sdtq_pkg::KIND_SUMMARY;
                r.last = 1'b1;
                if (armed_count > 0) begin
                    gap = armed_deadline[0] - now_ticks;
                    r.next_delay = (gap > {1'b0, DELAY_LIMIT}) ? DELAY_LIMIT : gap[30:0];
                end else begin
                    r.none_pending = 1'b1;
                end
                if (publish) pending_results.push_back(r);
            end
            default: begin
                // unused function code: no result, no state change
            end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result(sdtq_pkg::out_item_t got);
        sdtq_pkg::out_item_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected (%h)",
                                      results_seen, got));
        end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("result %0d kind: got %0d, expected %0d",
                                          results_seen, got.kind, want.kind));
            if (got.timer_out !== want.timer_out)
                report_mismatch($sformatf("result %0d timer_out: got %0d, expected %0d",
                                          results_seen, got.timer_out, want.timer_out));
            if (got.tag_out !== want.tag_out)
                report_mismatch($sformatf("result %0d tag_out: got %h, expected %h",
                                          results_seen, got.tag_out, want.tag_out));
            if (got.flag !== want.flag)
                report_mismatch($sformatf("result %0d flag: got %b, expected %b",
                                          results_seen, got.flag, want.flag));
            if (got.next_delay !== want.next_delay)
                report_mismatch($sformatf("result %0d next_delay: got %0d, expected %0d",
                                          results_seen, got.next_delay, want.next_delay));
            if (got.none_pending !== want.none_pending)
                report_mismatch($sformatf("result %0d none_pending: got %b, expected %b",
                                          results_seen, got.none_pending, want.none_pending));
            if (got.last !== want.last)
                report_mismatch($sformatf("result %0d last: got %b, expected %b",
                                          results_seen, got.last, want.last));
        end
        results_seen++;
    endtask

    // Observe both channels; predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                step_timer_model(s_data, cmd_check == CHECK_MODEL);
                if (cmd_check == CHECK_ONE_TYPED) pending_results.push_back(cmd_typed);
            end
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    // Stall the result channel at the phase's rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic sdtq_pkg::in_item_t mk_in(logic [1:0] func, logic [3:0] id,
                                                 logic [30:0] delay, logic [15:0] tag);
        sdtq_pkg::in_item_t it;
        it.func     = func;
        it.timer_id = id;
        it.delay    = delay;
        it.user_tag = tag;
        return it;
    endfunction

    function automatic sdtq_pkg::out_item_t mk_out(logic [1:0] kind, logic [3:0] id,
                                                   logic flag, logic none);
        sdtq_pkg::out_item_t r;
        r              = '0;
        r.kind         = kind;
        r.timer_out    = id;
        r.flag         = flag;
        r.none_pending = none;
        r.last         = 1'b1;
        return r;
    endfunction

    // Drive one command and hold it until the transfer happens
    task automatic send_command(sdtq_pkg::in_item_t cmd, check_mode_t mode,
                                sdtq_pkg::out_item_t typed);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= cmd;
        cmd_check <= mode;
        cmd_typed <= typed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold off the sender until every expected result has been seen
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [30:0] random_delay();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return 31'($urandom_range(5));
        if (pick < 85) return 31'($urandom_range(40));
        if (pick < 95) return 31'($urandom);
        return (pick < 97) ? 31'd0 : DELAY_LIMIT;
    endfunction

    // Mostly set and tick; some cancels and a little unused-code noise
    function automatic sdtq_pkg::in_item_t random_command();
        sdtq_pkg::in_item_t cmd;
        int                 pick;
        pick = $urandom_range(99);
        cmd  = mk_in(sdtq_pkg::FUNC_TICK, 4'($urandom), 31'($urandom), 16'($urandom));
        if (pick < 40) begin
            cmd.func  = sdtq_pkg::FUNC_SET;
            cmd.delay = random_delay();
        end else if (pick < 55) begin
            cmd.func = sdtq_pkg::FUNC_CANCEL;
        end else if (pick >= 95) begin
            cmd.func = FUNC_UNUSED;
        end
        return cmd;
    endfunction

    // Arm all timers on one deadline, then tick until they all expire together
    task automatic arm_every_timer_then_expire();
        int hold_ticks;
        int id;
        hold_ticks = $urandom_range(2);
        for (id = 0; id < TIMER_SLOTS; id++)
            send_command(mk_in(sdtq_pkg::FUNC_SET, 4'(id), 31'(hold_ticks), 16'($urandom)),
                         CHECK_MODEL, '0);
        repeat (hold_ticks + 1)
            send_command(mk_in(sdtq_pkg::FUNC_TICK, 4'($urandom), 31'($urandom),
                               16'($urandom)),
                         CHECK_MODEL, '0);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        sdtq_pkg::in_item_t cmd;
        int                 sent;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        arm_every_timer_then_expire();
        sent = 0;
        while (sent < RANDOM_PER_PHASE) begin
            cmd = random_command();
            send_command(cmd, CHECK_MODEL, '0);
            if (cmd.func != FUNC_UNUSED) sent++;
        end
        wait_for_drain();
    endtask

    // Main sequence: reset, directed table, four idling phases, final verdict
    initial begin
        now_ticks   = 32'd0;
        armed_count = 0;

        // extremes, re-arm, equal deadlines, cancels, ignored code, empty queue
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'hF, DELAY_LIMIT, 16'hFFFF), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SUMMARY, 4'd0, 1'b0, 1'b1)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_CANCEL, 4'd5, 31'd0, 16'h0000), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_CANCEL_REPLY, 4'd5, 1'b0, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(FUNC_UNUSED, 4'hF, DELAY_LIMIT, 16'hFFFF), CHECK_NO_RESULT, '0});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd0, 31'd0, 16'hFFFF), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd0, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'hF, DELAY_LIMIT, 16'h0000), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'hF, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd3, 31'd2, 16'h1234), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd3, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd4, 31'd2, 16'h5678), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd4, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd3, 31'd2, 16'hAAAA), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd3, 1'b0, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd0, 31'd0, 16'h0000), CHECK_MODEL, '0});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd9, 31'd77, 16'h5555), CHECK_MODEL, '0});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_CANCEL, 4'hF, 31'd0, 16'h0000), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_CANCEL_REPLY, 4'hF, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_CANCEL, 4'hF, 31'd0, 16'h0000), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_CANCEL_REPLY, 4'hF, 1'b0, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd0, 31'd0, 16'h0000), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SUMMARY, 4'd0, 1'b0, 1'b1)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd7, 31'd1, 16'h00FF), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd7, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd8, 31'd0, 16'hFF00), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd8, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd7, 31'd5, 16'h0F0F), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd7, 1'b0, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_CANCEL, 4'd8, 31'd0, 16'h0000), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_CANCEL_REPLY, 4'd8, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd8, 31'd3, 16'hF0F0), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd8, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd0, 31'd0, 16'h0000), CHECK_MODEL, '0});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd0, 31'd0, 16'h0000), CHECK_MODEL, '0});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd0, 31'd0, 16'h0000), CHECK_MODEL, '0});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_SET, 4'd2, 31'd0, 16'hC3C3), CHECK_ONE_TYPED,
            mk_out(sdtq_pkg::KIND_SET_REPLY, 4'd2, 1'b1, 1'b0)});
        directed_rows.push_back(stim_row_t'{
            mk_in(sdtq_pkg::FUNC_TICK, 4'd0, 31'd0, 16'h0000), CHECK_MODEL, '0});

        // hold reset, then release it
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table with no idling on either side
        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].mode, directed_rows[i].typed);
        wait_for_drain();

        // random traffic under each idling pattern
        run_phase(0, 0);
        run_phase(53, 0);
        run_phase(0, 53);
        run_phase(38, 38);

        // let any stray result show up
        receiver_stall_pct = 0;
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sdtq_pkg.sv
rtl/core/sdtq_cell.sv
rtl/core/sdtq_chain.sv
rtl/core/sorted_deadline_timer_queue_unit.sv
verif/testbench.sv
